/* src/bpmm_pkg.sv */
// Package for the battery power mode monitor: widths, mode codes, register
// indexes, reset values, config/result structs and the charge curve.
// No dependencies.
package bpmm_pkg;

    localparam int MV_W     = 13;
    localparam int HYST_W   = 10;
    localparam int PCT_W    = 7;
    localparam int HB_W     = 17;
    localparam int SLP_W    = 15;
    localparam int CFG_IDX_W = 3;
    localparam int THR_W    = MV_W + 1;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_CONSERVE = 2'd1,
        MODE_CRITICAL = 2'd2
    } t_mode;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONSERVE_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_USB_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_USB_HIGH     = 3'd4;

    // reset values
    localparam logic [MV_W-1:0]   RST_NORMAL_THR   = 13'd3700;
    localparam logic [MV_W-1:0]   RST_CONSERVE_THR = 13'd3400;
    localparam logic [HYST_W-1:0] RST_HYSTERESIS   = 10'd50;
    localparam logic [MV_W-1:0]   RST_USB_LOW      = 13'd1500;
    localparam logic [MV_W-1:0]   RST_USB_HIGH     = 13'd4250;

    // per-mode intervals
    localparam logic [HB_W-1:0]  HB_NORMAL    = 17'd30000;
    localparam logic [HB_W-1:0]  HB_CONSERVE  = 17'd60000;
    localparam logic [HB_W-1:0]  HB_CRITICAL  = 17'd120000;
    localparam logic [SLP_W-1:0] SLP_NONE     = 15'd0;
    localparam logic [SLP_W-1:0] SLP_CONSERVE = 15'd5000;
    localparam logic [SLP_W-1:0] SLP_CRITICAL = 15'd30000;

    // x/12 for x < 500: x * 2731 >> 15 (error stays below one twelfth)
    localparam int LIN_W       = 9;
    localparam int RECIP_W     = 12;
    localparam int PROD_W      = LIN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_12 = 12'd2731;
    localparam int RECIP_SHIFT = 15;

    typedef struct packed {
        logic [MV_W-1:0]   normal_thr;
        logic [MV_W-1:0]   conserve_thr;
        logic [HYST_W-1:0] hysteresis;
        logic [MV_W-1:0]   usb_low;
        logic [MV_W-1:0]   usb_high;
    } t_cfg;

    typedef struct packed {
        t_mode             power_mode;
        logic              mode_changed;
        logic              external_power;
        logic [PCT_W-1:0]  charge_percent;
        logic [HB_W-1:0]   heartbeat_ms;
        logic [SLP_W-1:0]  sleep_ms;
    } t_result;

    // stepped discharge curve, linear from 3.0 V to 3.5 V, zero below 3.0 V
    function automatic logic [PCT_W-1:0] charge_from_mv(input logic [MV_W-1:0] mv);
        logic [LIN_W-1:0]  lin;
        logic [PROD_W-1:0] prod;
        logic [PCT_W-1:0]  pct;
        lin  = LIN_W'(mv - 13'd3000);
        prod = PROD_W'(lin) * PROD_W'(RECIP_12);
        priority if (mv >= 13'd4200) pct = 7'd100;
        else if (mv >= 13'd4150)     pct = 7'd98;
        else if (mv >= 13'd4100)     pct = 7'd95;
        else if (mv >= 13'd4050)     pct = 7'd90;
        else if (mv >= 13'd3950)     pct = 7'd80;
        else if (mv >= 13'd3850)     pct = 7'd60;
        else if (mv >= 13'd3750)     pct = 7'd40;
        else if (mv >= 13'd3700)     pct = 7'd20;
        else if (mv >= 13'd3600)     pct = 7'd10;
        else if (mv >= 13'd3500)     pct = 7'd5;
        else if (mv < 13'd3000)      pct = 7'd0;
        else                         pct = PCT_W'(prod >> RECIP_SHIFT);
        return pct;
    endfunction

endpackage

/* src/bpmm_eval.sv */
// Combinational evaluation of one voltage sample: mode choice with
// hysteresis, external power detect, charge estimate and intervals.
// Depends on bpmm_pkg.
module bpmm_eval (
    input  logic [bpmm_pkg::MV_W-1:0] i_mv,
    input  bpmm_pkg::t_mode           i_cur_mode,
    input  bpmm_pkg::t_cfg            i_cfg,
    output bpmm_pkg::t_result         o_result
);

    logic                          ext;
    logic                          above_normal;
    logic                          above_conserve;
    logic [bpmm_pkg::THR_W-1:0]    thr_normal;
    logic [bpmm_pkg::THR_W-1:0]    thr_conserve;
    logic [bpmm_pkg::THR_W-1:0]    mv_ext;
    logic [bpmm_pkg::THR_W-1:0]    hyst_ext;
    bpmm_pkg::t_mode               next_mode;
    logic [bpmm_pkg::HB_W-1:0]     hb;
    logic [bpmm_pkg::SLP_W-1:0]    slp;

    assign mv_ext   = bpmm_pkg::THR_W'(i_mv);
    assign hyst_ext = bpmm_pkg::THR_W'(i_cfg.hysteresis);

    // climbing out of a lower mode needs the extra margin; code 3 counts as critical
    assign thr_normal = bpmm_pkg::THR_W'(i_cfg.normal_thr) +
                        ((i_cur_mode != bpmm_pkg::MODE_NORMAL) ? hyst_ext : '0);
    assign thr_conserve = bpmm_pkg::THR_W'(i_cfg.conserve_thr) +
                          ((i_cur_mode != bpmm_pkg::MODE_NORMAL &&
                            i_cur_mode != bpmm_pkg::MODE_CONSERVE) ? hyst_ext : '0);

    assign ext            = (i_mv < i_cfg.usb_low) || (i_mv > i_cfg.usb_high);
    assign above_normal   = mv_ext >= thr_normal;
    assign above_conserve = mv_ext >= thr_conserve;

    always_comb begin
        priority if (ext)       next_mode = bpmm_pkg::MODE_NORMAL;
        else if (above_normal)  next_mode = bpmm_pkg::MODE_NORMAL;
        else if (above_conserve) next_mode = bpmm_pkg::MODE_CONSERVE;
        else                    next_mode = bpmm_pkg::MODE_CRITICAL;
    end

    always_comb begin
        unique case (next_mode)
            bpmm_pkg::MODE_NORMAL: begin
                hb  = bpmm_pkg::HB_NORMAL;
                slp = bpmm_pkg::SLP_NONE;
            end
            bpmm_pkg::MODE_CONSERVE: begin
                hb  = bpmm_pkg::HB_CONSERVE;
                slp = bpmm_pkg::SLP_CONSERVE;
            end
            bpmm_pkg::MODE_CRITICAL: begin
                hb  = bpmm_pkg::HB_CRITICAL;
                slp = bpmm_pkg::SLP_CRITICAL;
            end
            default: begin
                hb  = bpmm_pkg::HB_NORMAL;
                slp = bpmm_pkg::SLP_NONE;
            end
        endcase
    end

    always_comb begin
        o_result.power_mode     = next_mode;
        o_result.mode_changed   = (next_mode != i_cur_mode);
        o_result.external_power = ext;
        o_result.charge_percent = bpmm_pkg::charge_from_mv(i_mv);
        o_result.heartbeat_ms   = hb;
        o_result.sleep_ms       = ext ? bpmm_pkg::SLP_NONE : slp;
    end

endmodule

/* src/battery_power_mode_monitor_top.sv */
// Top level of the battery power mode monitor: config registers, input
// register, mode state and result register around bpmm_eval.
// Depends on bpmm_pkg and bpmm_eval.
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ---------------------------------
//  in       in         i_in_valid / o_in_stall   i_battery_mv
//  out      out        o_out_valid / i_out_stall o_power_mode .. o_sleep_ms
//  cfg      in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A sample is registered in the input stage and its result in the result stage,
// which drives the outputs. One sample is taken every cycle while the output
// is not stalled.
// Reset (i_rst_n low, synchronous) empties both stages, returns the mode to
// NORMAL and loads the default thresholds. A stall on the output holds the
// result register; the input stage still fills once, after that the input
// side stalls too. The config port is always ready.
module battery_power_mode_monitor_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [bpmm_pkg::MV_W-1:0]         i_battery_mv,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_power_mode,
    output logic                              o_mode_changed,
    output logic                              o_external_power,
    output logic [bpmm_pkg::PCT_W-1:0]        o_charge_percent,
    output logic [bpmm_pkg::HB_W-1:0]         o_heartbeat_ms,
    output logic [bpmm_pkg::SLP_W-1:0]        o_sleep_ms,
    // config writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bpmm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bpmm_pkg::MV_W-1:0]         i_cfg_data
);

    // config registers
    bpmm_pkg::t_cfg     r_cfg;
    bpmm_pkg::t_cfg     n_cfg;

    // input stage
    logic                       r_in_valid;
    logic [bpmm_pkg::MV_W-1:0]  r_mv;

    // mode state: always the mode of the newest result loaded
    bpmm_pkg::t_mode    r_mode;

    // result stage
    logic               r_out_valid;
    bpmm_pkg::t_result  r_out;
    bpmm_pkg::t_result  eval_result;

    logic               out_load;
    logic               in_load;

    // the result register takes the input stage when empty or being drained;
    // the input register takes a new sample when it is empty or moving on
    assign out_load   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_load    = !r_in_valid || out_load;
    assign o_in_stall = !in_load;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bpmm_pkg::REG_NORMAL_THR:   n_cfg.normal_thr   = i_cfg_data;
                bpmm_pkg::REG_CONSERVE_THR: n_cfg.conserve_thr = i_cfg_data;
                bpmm_pkg::REG_HYSTERESIS:
                    n_cfg.hysteresis = i_cfg_data[bpmm_pkg::HYST_W-1:0];
                bpmm_pkg::REG_USB_LOW:      n_cfg.usb_low      = i_cfg_data;
                bpmm_pkg::REG_USB_HIGH:     n_cfg.usb_high     = i_cfg_data;
                default:                    n_cfg              = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_thr   <= bpmm_pkg::RST_NORMAL_THR;
            r_cfg.conserve_thr <= bpmm_pkg::RST_CONSERVE_THR;
            r_cfg.hysteresis   <= bpmm_pkg::RST_HYSTERESIS;
            r_cfg.usb_low      <= bpmm_pkg::RST_USB_LOW;
            r_cfg.usb_high     <= bpmm_pkg::RST_USB_HIGH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    bpmm_eval u_eval (
        .i_mv       (r_mv),
        .i_cur_mode (r_mode),
        .i_cfg      (r_cfg),
        .o_result   (eval_result)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= bpmm_pkg::MODE_NORMAL;
        end else begin
            if (in_load) begin
                r_in_valid <= i_in_valid;
            end
            if (out_load) begin
                r_mode <= eval_result.power_mode;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_mv <= i_battery_mv;
        end
        if (out_load) begin
            r_out <= eval_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_power_mode     = r_out.power_mode;
    assign o_mode_changed   = r_out.mode_changed;
    assign o_external_power = r_out.external_power;
    assign o_charge_percent = r_out.charge_percent;
    assign o_heartbeat_ms   = r_out.heartbeat_ms;
    assign o_sleep_ms       = r_out.sleep_ms;

`ifndef ASSERT_OFF
    // the mode state tracks the result on display
    a_mode_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.power_mode == r_mode))
        else $error("mode state differs from shown result");

    // external power forces normal mode with no sleep
    a_ext_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.external_power) |->
            (r_out.power_mode == bpmm_pkg::MODE_NORMAL && r_out.sleep_ms == '0))
        else $error("external power result not normal");

    // input side stalls only while the input stage holds a sample
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with free stage");

    // a held result does not change mode state
    a_hold_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_load |=> $stable(r_mode))
        else $error("mode changed without result load");
`endif

endmodule

/* tb/tb_battery_power_mode_monitor_top.sv */
// Self-checking testbench for battery_power_mode_monitor_top: directed and random
// voltage samples under random handshake gaps, checked against an in-bench predictor.
// Depends on bpmm_pkg and the RTL of battery_power_mode_monitor_top.
`timescale 1ns / 100ps

module tb_battery_power_mode_monitor_top;
    import bpmm_pkg::*;

    // Settle wait after the last result, before touching registers.
    localparam int SETTLE_CYCLES = 4;
    // Longest quiet stretch of a correct run is the receiver hold or a sender gap
    // plus a receiver stall; this limit is far beyond both.
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 150;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [MV_W-1:0]      i_battery_mv;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [1:0]           o_power_mode;
    logic                 o_mode_changed;
    logic                 o_external_power;
    logic [PCT_W-1:0]     o_charge_percent;
    logic [HB_W-1:0]      o_heartbeat_ms;
    logic [SLP_W-1:0]     o_sleep_ms;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [MV_W-1:0]      i_cfg_data;

    battery_power_mode_monitor_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_battery_mv     (i_battery_mv),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_power_mode     (o_power_mode),
        .o_mode_changed   (o_mode_changed),
        .o_external_power (o_external_power),
        .o_charge_percent (o_charge_percent),
        .o_heartbeat_ms   (o_heartbeat_ms),
        .o_sleep_ms       (o_sleep_ms),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Shadow copy of the register file and mode state, updated at the same
    // edges at which the block takes writes and samples.
    logic [MV_W-1:0]   normal_thr_sh   = RST_NORMAL_THR;
    logic [MV_W-1:0]   conserve_thr_sh = RST_CONSERVE_THR;
    logic [HYST_W-1:0] hyst_sh         = RST_HYSTERESIS;
    logic [MV_W-1:0]   usb_low_sh      = RST_USB_LOW;
    logic [MV_W-1:0]   usb_high_sh     = RST_USB_HIGH;
    t_mode             mode_sh         = MODE_NORMAL;

    t_result pending_results[$];   // predicted results, oldest first

    int n_samples       = 0;
    int n_results       = 0;
    int n_cfg_writes    = 0;
    int n_mode_changes  = 0;
    int n_in_stall_cyc  = 0;
    int n_errors        = 0;
    int quiet_cycles    = 0;

    // Handshake pacing, switched by the test tasks.
    bit tx_idle  = 1'b1;
    bit rx_idle  = 1'b1;
    int hold_req = 0;              // one long receiver hold, picked up by the stall process
    int walk_mv  = 3700;           // random-walk voltage for the ramp sequences

    //------------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------------

    // Stepped discharge curve; linear, truncated, between 3.0 V and 3.5 V.
    function automatic int curve_percent(input int mv);
        if (mv >= 4200) return 100;
        if (mv >= 4150) return 98;
        if (mv >= 4100) return 95;
        if (mv >= 4050) return 90;
        if (mv >= 3950) return 80;
        if (mv >= 3850) return 60;
        if (mv >= 3750) return 40;
        if (mv >= 3700) return 20;
        if (mv >= 3600) return 10;
        if (mv >= 3500) return 5;
        if (mv < 3000)  return 0;
        return ((mv - 3000) * 100) / 1200;
    endfunction

    // Works out the result of one sample and advances the shadow mode.
    function automatic t_result predict_mode_result(input logic [MV_W-1:0] mv);
        t_result r;
        t_mode   nxt;
        int      mv_i;
        int      normal_need;
        int      conserve_need;
        bit      ext;
        mv_i = int'(mv);
        ext  = (mv_i < int'(usb_low_sh)) || (mv_i > int'(usb_high_sh));
        // climbing sums are full width, no wrap
        normal_need   = int'(normal_thr_sh)
                      + ((mode_sh != MODE_NORMAL) ? int'(hyst_sh) : 0);
        conserve_need = int'(conserve_thr_sh)
                      + ((mode_sh == MODE_CRITICAL) ? int'(hyst_sh) : 0);
        if (ext)                         nxt = MODE_NORMAL;
        else if (mv_i >= normal_need)    nxt = MODE_NORMAL;
        else if (mv_i >= conserve_need)  nxt = MODE_CONSERVE;
        else                             nxt = MODE_CRITICAL;

        r.power_mode     = nxt;
        r.mode_changed   = (nxt != mode_sh);
        r.external_power = ext;
        r.charge_percent = PCT_W'(curve_percent(mv_i));
        case (nxt)
            MODE_CONSERVE: begin
                r.heartbeat_ms = HB_CONSERVE;
                r.sleep_ms     = SLP_CONSERVE;
            end
            MODE_CRITICAL: begin
                r.heartbeat_ms = HB_CRITICAL;
                r.sleep_ms     = SLP_CRITICAL;
            end
            default: begin
                r.heartbeat_ms = HB_NORMAL;
                r.sleep_ms     = SLP_NONE;
            end
        endcase
        if (ext) r.sleep_ms = SLP_NONE;
        mode_sh = nxt;
        return r;
    endfunction

    //------------------------------------------------------------------------
    // Clock, watchdog, receiver stall
    //------------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Ends the run if no handshake of any kind completes for too long.
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: per result a random stall while rx_idle is set, or one long hold
    // when a test asks for it. Stall changes only at falling edges.
    initial begin : out_stall_gen
        int n;
        i_out_stall = 1'b0;
        forever begin
            if (hold_req > 0) begin
                n        = hold_req;
                hold_req = 0;
            end else begin
                n = rx_idle ? $urandom_range(0, 19) : 0;
            end
            if (n > 0) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
            // wait for the next result to be taken, or for a hold request
            do @(posedge i_clk);
            while (!(o_out_valid && !i_out_stall) && hold_req == 0);
        end
    end

    //------------------------------------------------------------------------
    // Scoreboard: register writes, sample predictions and result checks,
    // all sampled at the rising edge.
    //------------------------------------------------------------------------

    always @(posedge i_clk) begin : scoreboard
        t_result exp_r;
        bit      any_hs;
        if (i_rst_n) begin
            any_hs = 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                any_hs = 1'b1;
                n_cfg_writes++;
                case (i_cfg_index)
                    REG_NORMAL_THR:   normal_thr_sh   = i_cfg_data;
                    REG_CONSERVE_THR: conserve_thr_sh = i_cfg_data;
                    REG_HYSTERESIS:   hyst_sh         = i_cfg_data[HYST_W-1:0];
                    REG_USB_LOW:      usb_low_sh      = i_cfg_data;
                    REG_USB_HIGH:     usb_high_sh     = i_cfg_data;
                    default: ;
                endcase
            end

            if (o_out_valid && !i_out_stall) begin
                any_hs = 1'b1;
                n_results++;
                if (pending_results.size() == 0) begin
                    $error("result with no sample pending: mode %0d pct %0d",
                           o_power_mode, o_charge_percent);
                    n_errors++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (o_power_mode !== exp_r.power_mode) begin
                        $error("power_mode: expected %0d, got %0d",
                               exp_r.power_mode, o_power_mode);
                        n_errors++;
                    end
                    if (o_mode_changed !== exp_r.mode_changed) begin
                        $error("mode_changed: expected %0d, got %0d",
                               exp_r.mode_changed, o_mode_changed);
                        n_errors++;
                    end
                    if (o_external_power !== exp_r.external_power) begin
                        $error("external_power: expected %0d, got %0d",
                               exp_r.external_power, o_external_power);
                        n_errors++;
                    end
                    if (o_charge_percent !== exp_r.charge_percent) begin
                        $error("charge_percent: expected %0d, got %0d",
                               exp_r.charge_percent, o_charge_percent);
                        n_errors++;
                    end
                    if (o_heartbeat_ms !== exp_r.heartbeat_ms) begin
                        $error("heartbeat_ms: expected %0d, got %0d",
                               exp_r.heartbeat_ms, o_heartbeat_ms);
                        n_errors++;
                    end
                    if (o_sleep_ms !== exp_r.sleep_ms) begin
                        $error("sleep_ms: expected %0d, got %0d",
                               exp_r.sleep_ms, o_sleep_ms);
                        n_errors++;
                    end
                end
            end

            if (i_in_valid && o_in_stall) n_in_stall_cyc++;
            if (i_in_valid && !o_in_stall) begin
                any_hs = 1'b1;
                n_samples++;
                exp_r = predict_mode_result(i_battery_mv);
                if (exp_r.mode_changed) n_mode_changes++;
                pending_results.push_back(exp_r);
            end

            quiet_cycles = any_hs ? 0 : quiet_cycles + 1;
        end
    end

    //------------------------------------------------------------------------
    // Driver tasks; inputs change only at falling edges.
    //------------------------------------------------------------------------

    // Offers one sample after a random gap and returns at the accepting edge.
    // Valid stays high into the next call when that call draws no gap.
    task automatic send_sample(input logic [MV_W-1:0] mv);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_battery_mv = mv;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drops valid and waits until every predicted result has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [MV_W-1:0] normal_thr,
                             input logic [MV_W-1:0] conserve_thr,
                             input logic [MV_W-1:0] hyst,
                             input logic [MV_W-1:0] usb_low,
                             input logic [MV_W-1:0] usb_high);
        write_reg(REG_NORMAL_THR,   normal_thr);
        write_reg(REG_CONSERVE_THR, conserve_thr);
        write_reg(REG_HYSTERESIS,   hyst);
        write_reg(REG_USB_LOW,      usb_low);
        write_reg(REG_USB_HIGH,     usb_high);
    endtask

    function automatic logic [MV_W-1:0] clamp_mv(input int v);
        if (v < 0)    return '0;
        if (v > 8191) return '1;
        return MV_W'(v);
    endfunction

    // Mostly slow ramps and samples around the active thresholds, so that the
    // mode climbs and falls through its hysteresis; the rest is full range.
    function automatic logic [MV_W-1:0] next_sample();
        int pick;
        int base;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            if ($urandom_range(0, 19) == 0) walk_mv = $urandom_range(2800, 4500);
            else walk_mv = int'(clamp_mv(walk_mv + int'($urandom_range(0, 160)) - 80));
            return MV_W'(walk_mv);
        end
        if (pick < 80) begin
            case ($urandom_range(0, 5))
                0:       base = int'(normal_thr_sh);
                1:       base = int'(normal_thr_sh) + int'(hyst_sh);
                2:       base = int'(conserve_thr_sh);
                3:       base = int'(conserve_thr_sh) + int'(hyst_sh);
                4:       base = int'(usb_low_sh);
                default: base = int'(usb_high_sh);
            endcase
            return clamp_mv(base + int'($urandom_range(0, 120)) - 60);
        end
        return MV_W'($urandom_range(0, 8191));
    endfunction

    //------------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------------

    // Reset thresholds: field extremes, every curve step, the linear part,
    // both external power bounds and both hysteresis climbs.
    task automatic test_reset_defaults();
        int vals [26] = '{0, 8191, 3399, 1499, 1500, 3449, 3450, 3749, 3750, 3699,
                          3399, 3000, 3011, 3012, 3499, 3500, 3600, 3700, 3850,
                          3950, 4050, 4100, 4150, 4200, 4250, 4251};
        foreach (vals[k]) send_sample(MV_W'(vals[k]));
        wait_idle();
    endtask

    // Register extremes: thresholds and hysteresis all zero, then all at maximum (climb
    // sums past 13 bits), inverted external power bounds, and hysteresis data wider than its field.
    task automatic test_register_extremes();
        write_all(13'd0, 13'd0, 13'd0, 13'd0, 13'd8191);
        send_sample(13'd0);
        send_sample(13'd8191);
        send_sample(13'd4000);
        wait_idle();

        write_all(13'd8191, 13'd8191, 13'd1023, 13'd0, 13'd8191);
        send_sample(13'd8191);    // normal, no margin needed yet
        send_sample(13'd100);     // down to critical
        send_sample(13'd8191);    // cannot climb: needs 9214
        send_sample(13'd0);
        wait_idle();

        // low bound above high bound: every sample reads as external power
        write_all(RST_NORMAL_THR, RST_CONSERVE_THR, 13'(RST_HYSTERESIS), 13'd8191, 13'd0);
        send_sample(13'd0);
        send_sample(13'd3000);
        send_sample(13'd8191);
        wait_idle();

        write_reg(REG_HYSTERESIS, 13'h1FFF);  // only the low ten bits stick
        write_all(RST_NORMAL_THR, RST_CONSERVE_THR, 13'h1C00 | 13'(RST_HYSTERESIS),
                  RST_USB_LOW, RST_USB_HIGH);
        send_sample(13'd3300);
        send_sample(13'd3460);
        wait_idle();
    endtask

    // Random phases: realistic and fully random register sets, with some
    // phases run back to back on both sides and the rest with random gaps.
    task automatic test_random_phases(input int n_phases, input int per_phase);
        for (int p = 0; p < n_phases; p++) begin
            if (p % 2 == 0) begin
                write_all(MV_W'($urandom_range(3500, 4000)),
                          MV_W'($urandom_range(3100, 3500)),
                          MV_W'($urandom_range(0, 150)),
                          MV_W'($urandom_range(1000, 3000)),
                          MV_W'($urandom_range(4000, 4500)));
            end else begin
                write_all(MV_W'($urandom_range(0, 8191)), MV_W'($urandom_range(0, 8191)),
                          MV_W'($urandom_range(0, 8191)), MV_W'($urandom_range(0, 4095)),
                          MV_W'($urandom_range(2048, 8191)));
            end
            tx_idle = (p % 3 != 0);
            rx_idle = (p % 3 != 0);
            walk_mv = $urandom_range(3000, 4300);
            for (int k = 0; k < per_phase; k++) send_sample(next_sample());
            wait_idle();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Receiver holds off while the sender keeps offering back to back, so the
    // block fills and stalls its input.
    task automatic test_output_backpressure();
        write_all(RST_NORMAL_THR, RST_CONSERVE_THR, 13'(RST_HYSTERESIS),
                  RST_USB_LOW, RST_USB_HIGH);
        tx_idle  = 1'b0;
        hold_req = HOLD_CYCLES;
        for (int k = 0; k < 20; k++) send_sample(next_sample());
        wait_idle();
        tx_idle = 1'b1;
    endtask

    // Sender stops until every result is back, then carries on.
    task automatic test_sender_pause();
        for (int k = 0; k < 12; k++) send_sample(next_sample());
        wait_idle();
        for (int k = 0; k < 12; k++) send_sample(next_sample());
        wait_idle();
    endtask

    //------------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------------

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_battery_mv = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_NORMAL_THR;
        i_cfg_data   = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_phases(6, 55);
        test_output_backpressure();
        test_sender_pause();

        wait_idle();
        if (pending_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_results.size());
            n_errors++;
        end

        $display("Run covered %0d samples and %0d results over %0d register writes,",
                 n_samples, n_results, n_cfg_writes);
        $display("with %0d mode changes and %0d input stall cycles; %0d mismatches.",
                 n_mode_changes, n_in_stall_cyc, n_errors);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
